// ===== rtl/oltq_pkg.sv =====
// Shared types and constants for the origin-line LED matrix rasterizer.
// No dependencies; used by every module of the block.
package oltq_pkg;

	// Default largest coordinate magnitude
	localparam int MAX_INDEX_DEF = 7;

	// Command codes on the result channel
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LED   = 2'd1;
	localparam logic [1:0] CMD_FILL  = 2'd2;

	// Quadrant display numbers
	localparam logic [1:0] QUAD_UR = 2'd0;	// x >= 0, y >= 0
	localparam logic [1:0] QUAD_LR = 2'd1;	// x > 0, y < 0
	localparam logic [1:0] QUAD_LL = 2'd2;	// x <= 0, y <= 0
	localparam logic [1:0] QUAD_UL = 2'd3;	// x < 0, y > 0

	// Input word: target pixel
	typedef struct packed {
		logic signed [3:0] target_x;
		logic signed [3:0] target_y;
	} in_word_t;

	// Result word: one display command
	typedef struct packed {
		logic [1:0] command;
		logic [1:0] display_index;
		logic [2:0] led_row;
		logic [2:0] led_column;
		logic       last_of_run;
	} out_word_t;

	// Classified segment handed from front to back
	typedef struct packed {
		logic              is_origin;
		logic              major_y;	// walk along y
		logic signed [3:0] v;		// major coordinate of target
		logic signed [3:0] w;		// minor coordinate of target
		logic [1:0]        quad;
	} job_t;

endpackage

// ===== rtl/oltq_front.sv =====
// Front end: accepts target words, saturates and classifies them, and keeps
// them in a two-entry job queue. Depends on oltq_pkg.
module oltq_front #(
	parameter int MAX_INDEX = oltq_pkg::MAX_INDEX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  oltq_pkg::in_word_t target,
	output logic              job_valid,
	output oltq_pkg::job_t    job,
	input  logic              job_pop
);

	localparam int LIM = (MAX_INDEX < 7) ? MAX_INDEX : 7;
	localparam logic signed [3:0] LIM_P = 4'(LIM);
	localparam logic signed [3:0] LIM_N = 4'(-LIM);

	logic signed [3:0] x_in, y_in, x_c, y_c;
	logic [2:0]        ax, ay;
	logic              x_neg, y_neg, x_zero, y_zero;
	oltq_pkg::job_t    job_new;
	oltq_pkg::job_t    q_mem [2];
	logic              wr_q, rd_q;
	logic [1:0]        cnt_q;
	logic              wr_en, rd_en;

	// Saturate coordinates to the drawable range
	assign x_in = target.target_x;
	assign y_in = target.target_y;
	assign x_c  = (x_in > LIM_P) ? LIM_P : ((x_in < LIM_N) ? LIM_N : x_in);
	assign y_c  = (y_in > LIM_P) ? LIM_P : ((y_in < LIM_N) ? LIM_N : y_in);

	// Magnitudes and signs
	assign x_neg  = x_c[3];
	assign y_neg  = y_c[3];
	assign x_zero = (x_c == 4'sd0);
	assign y_zero = (y_c == 4'sd0);
	assign ax     = x_neg ? 3'(-x_c) : x_c[2:0];
	assign ay     = y_neg ? 3'(-y_c) : y_c[2:0];

	// Classify: major axis, quadrant, origin case
	always_comb begin
		job_new.is_origin = x_zero && y_zero;
		job_new.major_y   = !(ax > ay);
		job_new.v         = job_new.major_y ? y_c : x_c;
		job_new.w         = job_new.major_y ? x_c : y_c;
		if (!x_neg && !y_neg) begin
			job_new.quad = oltq_pkg::QUAD_UR;
		end else if (!x_neg && !x_zero && y_neg) begin
			job_new.quad = oltq_pkg::QUAD_LR;
		end else if ((x_neg || x_zero) && (y_neg || y_zero)) begin
			job_new.quad = oltq_pkg::QUAD_LL;
		end else begin
			job_new.quad = oltq_pkg::QUAD_UL;
		end
	end

	// Job queue control
	assign full      = (cnt_q == 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign wr_en     = push && !full;
	assign rd_en     = job_pop && job_valid;
	assign job       = q_mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wr_q <= !wr_q;
			if (rd_en) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	// Queue storage, payload only
	always_ff @(posedge clk) begin
		if (wr_en) q_mem[wr_q] <= job_new;
	end

endmodule

// ===== rtl/oltq_back.sv =====
// Back end: walks one segment per job, Bresenham style, and emits display
// commands into an output register. Depends on oltq_pkg.
module oltq_back #(
	parameter int MAX_INDEX = oltq_pkg::MAX_INDEX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  oltq_pkg::job_t     job,
	output logic               job_pop,
	output logic               empty,
	input  logic               pop,
	output oltq_pkg::out_word_t result
);

	localparam logic [2:0] M3 = 3'(MAX_INDEX);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_FILL = 3'b010,
		ST_STEP = 3'b100
	} state_t;

	state_t              state_q;
	logic signed [3:0]   i_q, j_q, n_q, i1_q;
	logic [2:0]          d_q;
	logic signed [5:0]   e_q, e_sum, d_w, n_w;
	logic                major_y_q;
	logic [1:0]          quad_q;
	oltq_pkg::out_word_t out_q, pt_word;
	logic                out_valid_q, adv, at_end;
	logic signed [3:0]   px, py, ld_n;
	logic [2:0]          row, col;

	assign adv     = !out_valid_q || pop;
	assign empty   = !out_valid_q;
	assign result  = out_q;
	assign job_pop = adv && (state_q == ST_IDLE) && job_valid;

	// Error update for the next step of the minor coordinate
	assign n_w      = 6'(n_q);
	assign d_w      = $signed({3'b000, d_q});
	assign e_sum    = e_q + (n_w <<< 1);
	assign at_end   = (i_q == i1_q);
	assign ld_n     = job.v[3] ? -job.w : job.w;

	// Map the current point to its display row and column, modulo 8
	always_comb begin
		px = major_y_q ? j_q : i_q;
		py = major_y_q ? i_q : j_q;
		case (quad_q)
			oltq_pkg::QUAD_UR: begin
				row = py[2:0];
				col = M3 - px[2:0];
			end
			oltq_pkg::QUAD_LR: begin
				row = py[2:0] + M3;
				col = M3 - px[2:0];
			end
			oltq_pkg::QUAD_LL: begin
				row = 3'd0 - py[2:0];
				col = M3 + px[2:0];
			end
			default: begin
				row = M3 - py[2:0];
				col = M3 + px[2:0];
			end
		endcase
		pt_word.command       = oltq_pkg::CMD_LED;
		pt_word.display_index = quad_q;
		pt_word.led_row       = row;
		pt_word.led_column    = col;
		pt_word.last_of_run   = at_end;
	end

	// Sequencer and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			case (state_q)
				ST_IDLE: begin
					out_valid_q <= job_valid;
					if (job_valid) state_q <= job.is_origin ? ST_FILL : ST_STEP;
				end
				ST_FILL: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_STEP: begin
					out_valid_q <= 1'b1;
					if (at_end) state_q <= ST_IDLE;
				end
				default: begin
					out_valid_q <= 1'b0;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk registers and output word
	always_ff @(posedge clk) begin
		if (adv) begin
			case (state_q)
				ST_IDLE: begin
					out_q     <= '{command: oltq_pkg::CMD_CLEAR, display_index: 2'd0,
					               led_row: 3'd0, led_column: 3'd0, last_of_run: 1'b0};
					major_y_q <= job.major_y;
					quad_q    <= job.quad;
					n_q       <= ld_n;
					d_q       <= job.v[3] ? 3'(-job.v) : job.v[2:0];
					i1_q      <= job.v[3] ? 4'sd0 : job.v;
					i_q       <= job.v[3] ? job.v : 4'sd0;
					j_q       <= job.v[3] ? job.w : 4'sd0;
					e_q       <= 6'sd0;
				end
				ST_FILL: begin
					out_q <= '{command: oltq_pkg::CMD_FILL, display_index: 2'd0,
					           led_row: 3'd0, led_column: 3'd0, last_of_run: 1'b1};
				end
				ST_STEP: begin
					out_q <= pt_word;
					i_q   <= i_q + 4'sd1;
					if (e_sum > d_w) begin
						j_q <= j_q + 4'sd1;
						e_q <= e_sum - (d_w <<< 1);
					end else if (e_sum <= -d_w) begin
						j_q <= j_q - 4'sd1;
						e_q <= e_sum + (d_w <<< 1);
					end else begin
						e_q <= e_sum;
					end
				end
				default: begin
					out_q <= out_q;
				end
			endcase
		end
	end

endmodule

// ===== rtl/origin_line_to_quad_led_matrix.sv =====
// Top level of the origin-line LED matrix rasterizer.
// Instantiates oltq_front and oltq_back; types and constants from oltq_pkg.
//
// Usage:
//   Input channel: a target word (target_x, target_y) is taken on a rising
//   edge with push high and full low. Coordinates are saturated to
//   +-min(MAX_INDEX, 7).
//   Result channel: while empty is low, result holds the oldest command word;
//   it is taken on a rising edge with pop high. Each target produces a clear
//   word, then either one fill word (target at the origin) or one LED word
//   per step of the major axis; last_of_run marks the final word.
//   Path: an accepted target waits in the job queue; its clear word is
//   registered onto result from there when the back end is idle.
//   Sequencer: a target occupies the back end for its clear word and then
//   its fill word or LED words, one word per cycle while pop keeps the
//   output register free. A two-entry job queue lets the input side keep
//   taking targets while the sequencer is busy.
//   Stall: when pop stays low the sequencer holds its word and waits; the
//   job queue fills and then full rises.
//   Reset: arst_n clears the queue and the sequencer; no words are pending.
module origin_line_to_quad_led_matrix #(
	parameter int MAX_INDEX = oltq_pkg::MAX_INDEX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  oltq_pkg::in_word_t  target,
	output logic                empty,
	input  logic                pop,
	output oltq_pkg::out_word_t result
);

	logic           job_valid, job_pop;
	oltq_pkg::job_t job;

	// Accept and classify
	oltq_front #(.MAX_INDEX(MAX_INDEX)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.target    (target),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	// Walk and emit
	oltq_back #(.MAX_INDEX(MAX_INDEX)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
